// ===== rtl/cc20_pkg.sv =====
`default_nettype none

package cc20_pkg;

    // Double rounds per keystream block (RFC 8439 uses ten)
    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam int WORD_W   = 32;
    localparam int NWORDS   = 16;
    localparam int POS_W    = 6;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    // One add-xor-rotate step of the quarter round, applied to all four lanes
    localparam logic [1:0] STEP_AD16 = 2'd0;
    localparam logic [1:0] STEP_CB12 = 2'd1;
    localparam logic [1:0] STEP_AD8  = 2'd2;
    localparam logic [1:0] STEP_CB7  = 2'd3;

    localparam logic [4:0] ROT_16 = 5'd16;
    localparam logic [4:0] ROT_12 = 5'd12;
    localparam logic [4:0] ROT_8  = 5'd8;
    localparam logic [4:0] ROT_7  = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_A    = 3'd0,
        CFG_KEY_B    = 3'd1,
        CFG_KEY_C    = 3'd2,
        CFG_KEY_D    = 3'd3,
        CFG_NONCE_LO = 3'd4,
        CFG_NONCE_HI = 3'd5,
        CFG_INIT_CTR = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             load;     // start a block: load state, capture word
        logic             new_msg;  // counter from initial value
        logic             step_en;  // run one ARX step
        logic [1:0]       step;
        logic             diag;     // diagonal half of the double round
        logic             feed;     // feed-forward add
        logic             pass;     // output from incoming word
        logic             emit;     // output from held word
        logic [POS_W-1:0] pos;      // keystream byte index
    } t_dp_cmd;

    typedef struct packed {
        logic hold_last;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cc20_in_if.sv =====
`default_nettype none

interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cc20_out_if.sv =====
`default_nettype none

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last_out;

    modport source (output valid, output cipher_byte, output last_out, input ready);
    modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
`default_nettype none

// Channel     Dir  Payload                      Handshake
// i_data_ch   in   data_byte[7:0], is_last      valid/ready
// o_cipher_ch out  cipher_byte[7:0], last_out   valid/ready
// i_cfg_*     in   idx[2:0], data[63:0]         write enable only
//
// A word inside a keystream block is accepted and loaded into the output
// register on the same edge. The first word of each 64-byte block loads
// the output once the block is generated (one ARX step per cycle across
// four quarter-round lanes, feed-forward, emit), and the next word is
// taken when the output register is free. All rounds share one ARX stage.
// Reset is synchronous, active low, and clears the controller and the
// configuration registers (counter 1). Hold the input while a block is
// generated and while the output word waits for ready.

module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cc20_in_if.sink                             i_data_ch,
    cc20_out_if.source                          o_cipher_ch,
    input  wire logic                           i_cfg_we,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cc20_pkg::CFG_W-1:0]     i_cfg_data
);

    cc20_pkg::t_dp_cmd  cmd;
    cc20_pkg::t_dp_stat stat;

    // sequence the rounds and own all handshakes
    cc20_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_data_ch.valid),
        .i_in_last   (i_data_ch.is_last),
        .o_in_ready  (i_data_ch.ready),
        .o_out_valid (o_cipher_ch.valid),
        .i_out_ready (o_cipher_ch.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // hold key state, run the block function, XOR the keystream
    cc20_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_byte  (i_data_ch.data_byte),
        .i_in_last  (i_data_ch.is_last),
        .o_out_byte (o_cipher_ch.cipher_byte),
        .o_out_last (o_cipher_ch.last_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

`default_nettype wire

// ===== rtl/cc20_ctrl.sv =====
`default_nettype none

module cc20_ctrl #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cc20_pkg::t_dp_cmd       o_cmd,
    input  wire cc20_pkg::t_dp_stat i_stat
);

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_FEED  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_step, n_step;
    logic                       r_diag, n_diag;
    logic [DR_W-1:0]            r_dround, n_dround;
    logic [cc20_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_started, n_started;
    logic                       r_out_valid, n_out_valid;

    logic out_free;
    logic out_load;
    logic adv;
    logic adv_last;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_diag    = r_diag;
        n_dround  = r_dround;
        o_in_ready = 1'b0;
        out_load  = 1'b0;
        adv       = 1'b0;
        adv_last  = 1'b0;
        o_cmd         = '0;
        o_cmd.step    = r_step;
        o_cmd.diag    = r_diag;
        o_cmd.pos     = r_pos;
        o_cmd.new_msg = !r_started;

        case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (r_pos == '0) begin
                        // block boundary: generate keystream first
                        o_cmd.load = 1'b1;
                        n_state    = S_ROUND;
                        n_step     = cc20_pkg::STEP_AD16;
                        n_diag     = 1'b0;
                        n_dround   = '0;
                    end else begin
                        o_cmd.pass = 1'b1;
                        out_load   = 1'b1;
                        adv        = 1'b1;
                        adv_last   = i_in_last;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.step_en = 1'b1;
                n_step        = r_step + 2'd1;
                if (r_step == cc20_pkg::STEP_CB7) begin
                    n_diag = !r_diag;
                    if (r_diag) begin
                        if (r_dround == DR_W'(DOUBLE_ROUNDS - 1)) begin
                            n_state = S_FEED;
                        end else begin
                            n_dround = r_dround + DR_W'(1);
                        end
                    end
                end
            end
            S_FEED: begin
                o_cmd.feed = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                out_load   = 1'b1;
                adv        = 1'b1;
                adv_last   = i_stat.hold_last;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pos     = r_pos;
        n_started = r_started;
        if (adv) begin
            n_pos     = adv_last ? '0 : r_pos + cc20_pkg::POS_W'(1);
            n_started = !adv_last;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= cc20_pkg::STEP_AD16;
            r_diag      <= 1'b0;
            r_dround    <= '0;
            r_pos       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_diag      <= n_diag;
            r_dround    <= n_dround;
            r_pos       <= n_pos;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cc20_dp.sv =====
`default_nettype none

module cc20_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cc20_pkg::t_dp_cmd             i_cmd,
    output cc20_pkg::t_dp_stat                 o_stat,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_in_last,
    output logic [7:0]                         o_out_byte,
    output logic                               o_out_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cc20_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int WW = cc20_pkg::WORD_W;
    localparam int NW = cc20_pkg::NWORDS;

    logic [63:0] r_key_a, r_key_b, r_key_c, r_key_d, r_nonce_lo;
    logic [31:0] r_nonce_hi, r_init_ctr;

    logic [WW-1:0] r_w [NW];      // working state, keystream after feed-forward
    logic [WW-1:0] r_cur_ctr;
    logic [7:0]    r_hold_byte;
    logic          r_hold_last;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [WW-1:0] init_w [NW];
    logic [WW-1:0] rnd_w [NW];
    logic [WW-1:0] ctr_sel;
    logic [WW-1:0] ks_word;
    logic [7:0]    ks_byte;

    assign o_stat.hold_last = r_hold_last;
    assign o_out_byte       = r_out_byte;
    assign o_out_last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a    <= '0;
            r_key_b    <= '0;
            r_key_c    <= '0;
            r_key_d    <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_init_ctr <= 32'd1;
        end else if (i_cfg_we) begin
            case (cc20_pkg::t_cfg_idx'(i_cfg_idx))
                cc20_pkg::CFG_KEY_A:    r_key_a    <= i_cfg_data;
                cc20_pkg::CFG_KEY_B:    r_key_b    <= i_cfg_data;
                cc20_pkg::CFG_KEY_C:    r_key_c    <= i_cfg_data;
                cc20_pkg::CFG_KEY_D:    r_key_d    <= i_cfg_data;
                cc20_pkg::CFG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                cc20_pkg::CFG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                cc20_pkg::CFG_INIT_CTR: r_init_ctr <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i] = cc20_pkg::SIGMA[i];
        end
        init_w[4]  = r_key_a[31:0];
        init_w[5]  = r_key_a[63:32];
        init_w[6]  = r_key_b[31:0];
        init_w[7]  = r_key_b[63:32];
        init_w[8]  = r_key_c[31:0];
        init_w[9]  = r_key_c[63:32];
        init_w[10] = r_key_d[31:0];
        init_w[11] = r_key_d[63:32];
        init_w[12] = r_cur_ctr;
        init_w[13] = r_nonce_lo[31:0];
        init_w[14] = r_nonce_lo[63:32];
        init_w[15] = r_nonce_hi;
    end

    assign ctr_sel = i_cmd.new_msg ? r_init_ctr : r_cur_ctr + 32'd1;
    assign ks_word = r_w[i_cmd.pos[5:2]];
    assign ks_byte = ks_word[{i_cmd.pos[1:0], 3'b000} +: 8];

    // Four column lanes; rows are rotated after the last step of each half
    // so the diagonal half runs on the same lanes.
    always_comb begin
        logic [WW-1:0] a, b, c, d;
        logic [WW-1:0] lane_w [NW];
        logic [1:0]    src;
        for (int i = 0; i < 4; i++) begin
            a = r_w[i];
            b = r_w[4 + i];
            c = r_w[8 + i];
            d = r_w[12 + i];
            case (i_cmd.step)
                cc20_pkg::STEP_AD16: begin
                    a = a + b;
                    d = cc20_pkg::rotl(d ^ a, cc20_pkg::ROT_16);
                end
                cc20_pkg::STEP_CB12: begin
                    c = c + d;
                    b = cc20_pkg::rotl(b ^ c, cc20_pkg::ROT_12);
                end
                cc20_pkg::STEP_AD8: begin
                    a = a + b;
                    d = cc20_pkg::rotl(d ^ a, cc20_pkg::ROT_8);
                end
                cc20_pkg::STEP_CB7: begin
                    c = c + d;
                    b = cc20_pkg::rotl(b ^ c, cc20_pkg::ROT_7);
                end
                default: begin
                end
            endcase
            lane_w[i]      = a;
            lane_w[4 + i]  = b;
            lane_w[8 + i]  = c;
            lane_w[12 + i] = d;
        end
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < 4; i++) begin
                if (i_cmd.step == cc20_pkg::STEP_CB7) begin
                    src = i_cmd.diag ? 2'(i - r) : 2'(i + r);
                end else begin
                    src = 2'(i);
                end
                rnd_w[4 * r + i] = lane_w[4 * r + int'(src)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < NW; i++) begin
                r_w[i] <= (i == 12) ? ctr_sel : init_w[i];
            end
            r_cur_ctr   <= ctr_sel;
            r_hold_byte <= i_in_byte;
            r_hold_last <= i_in_last;
        end else if (i_cmd.step_en) begin
            r_w <= rnd_w;
        end else if (i_cmd.feed) begin
            for (int i = 0; i < NW; i++) begin
                r_w[i] <= r_w[i] + init_w[i];
            end
        end

        if (i_cmd.pass) begin
            r_out_byte <= i_in_byte ^ ks_byte;
            r_out_last <= i_in_last;
        end else if (i_cmd.emit) begin
            r_out_byte <= r_hold_byte ^ ks_byte;
            r_out_last <= r_hold_last;
        end
    end

endmodule

`default_nettype wire

// ===== bench/chacha20_stream_cipher_chk.sv =====
`timescale 1ns / 100ps

module chacha20_stream_cipher_chk #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cc20_in_if                             i_data_mon,
    cc20_out_if                            i_cipher_mon,
    input  logic                           i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cc20_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_bytes_checked
);
    import cc20_pkg::*;

    localparam logic [31:0] CHACHA_CONST [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_out;
    } cipher_word_t;

    // Shadow copy of the register file
    logic [63:0] key_a, key_b, key_c, key_d, nonce_lo;
    logic [31:0] nonce_hi, ctr_init;

    // Keystream generator state
    logic [31:0] ks_words [16];
    logic [31:0] mix_w [16];
    logic [31:0] blk_ctr;
    logic [5:0]  byte_pos;
    logic        msg_open;

    cipher_word_t cipher_due [$];
    int           mismatch_count;
    int           bytes_checked;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter(input int a, input int b, input int c, input int d);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
    endfunction

    // Build one 64-byte keystream block for the given counter
    function automatic void chacha_block(input logic [31:0] ctr);
        logic [31:0] init_w [16];
        int          r;
        int          i;
        for (i = 0; i < 4; i++)
            init_w[i] = CHACHA_CONST[i];
        init_w[4]  = key_a[31:0];  init_w[5]  = key_a[63:32];
        init_w[6]  = key_b[31:0];  init_w[7]  = key_b[63:32];
        init_w[8]  = key_c[31:0];  init_w[9]  = key_c[63:32];
        init_w[10] = key_d[31:0];  init_w[11] = key_d[63:32];
        init_w[12] = ctr;
        init_w[13] = nonce_lo[31:0];
        init_w[14] = nonce_lo[63:32];
        init_w[15] = nonce_hi;
        for (i = 0; i < 16; i++)
            mix_w[i] = init_w[i];
        for (r = 0; r < DOUBLE_ROUNDS; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
            ks_words[i] = mix_w[i] + init_w[i];
    endfunction

    function automatic cipher_word_t encrypt_byte(input logic [7:0] plain, input logic last);
        logic [7:0]   ks;
        cipher_word_t w;
        if (!msg_open) begin
            blk_ctr  = ctr_init;
            msg_open = 1'b1;
            byte_pos = '0;
        end
        if (byte_pos == 6'd0) begin
            chacha_block(blk_ctr);
            blk_ctr = blk_ctr + 32'd1;
        end
        ks = ks_words[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
        w.cipher_byte = plain ^ ks;
        w.last_out    = last;
        if (last) begin
            msg_open = 1'b0;
            byte_pos = '0;
        end else begin
            byte_pos = byte_pos + 6'd1;
        end
        return w;
    endfunction

    function automatic void note_fail(input string what, input cipher_word_t due,
                                      input cipher_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t chk: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, due.cipher_byte, due.last_out,
                     got.cipher_byte, got.last_out);
    endfunction

    always @(posedge i_clk) begin
        cipher_word_t due;
        cipher_word_t got;
        if (!i_rst_n) begin
            key_a    = '0;
            key_b    = '0;
            key_c    = '0;
            key_d    = '0;
            nonce_lo = '0;
            nonce_hi = '0;
            ctr_init = 32'd1;
            blk_ctr  = '0;
            byte_pos = '0;
            msg_open = 1'b0;
            cipher_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_A:    key_a    = i_cfg_data;
                    CFG_KEY_B:    key_b    = i_cfg_data;
                    CFG_KEY_C:    key_c    = i_cfg_data;
                    CFG_KEY_D:    key_d    = i_cfg_data;
                    CFG_NONCE_LO: nonce_lo = i_cfg_data;
                    CFG_NONCE_HI: nonce_hi = i_cfg_data[31:0];
                    CFG_INIT_CTR: ctr_init = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            // Compare before predicting: a result never leaves on its own accept edge
            if (i_cipher_mon.valid && i_cipher_mon.ready) begin
                got.cipher_byte = i_cipher_mon.cipher_byte;
                got.last_out    = i_cipher_mon.last_out;
                if (cipher_due.size() == 0) begin
                    note_fail("no byte due", '0, got);
                end else begin
                    due = cipher_due.pop_front();
                    if (due.cipher_byte !== got.cipher_byte || due.last_out !== got.last_out)
                        note_fail("mismatch", due, got);
                end
                bytes_checked++;
            end
            if (i_data_mon.valid && i_data_mon.ready)
                cipher_due.push_back(encrypt_byte(i_data_mon.data_byte, i_data_mon.is_last));
        end
        o_fail_count    <= mismatch_count;
        o_pending       <= cipher_due.size();
        o_bytes_checked <= bytes_checked;
    end

endmodule

// ===== bench/chacha20_stream_cipher_tb.sv =====
`timescale 1ns / 100ps

module chacha20_stream_cipher_tb;

    localparam int DOUBLE_ROUNDS  = cc20_pkg::DOUBLE_ROUNDS_DEF;
    // First word of a block waits for the whole round sequence
    localparam int BLOCK_LATENCY  = 8 * DOUBLE_ROUNDS + 3;
    localparam int LONG_HOLD      = 300;
    // Longest quiet stretch of a correct run is one long hold plus a block, taken 4x
    localparam int WATCHDOG_LIMIT = 4 * (LONG_HOLD + BLOCK_LATENCY + 100);
    // Index past the last register: writes to it must be dropped
    localparam logic [cc20_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam logic [7:0] CORNER_BYTES [8] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [cc20_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [cc20_pkg::CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int bytes_checked;

    // Knobs shared between the stimulus and the sink process
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;

    int bytes_sent;
    int msgs_sent;
    int settings_used;

    cc20_in_if  data_ch ();
    cc20_out_if cipher_ch ();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_ch   (data_ch),
        .o_cipher_ch (cipher_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    chacha20_stream_cipher_chk #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_data_mon      (data_ch),
        .i_cipher_mon    (cipher_ch),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one word, with an occasional idle burst ahead of it; return on the accept edge
    task automatic send_word(input logic [7:0] plain, input logic last);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            data_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        data_ch.valid     <= 1'b1;
        data_ch.data_byte <= plain;
        data_ch.is_last   <= last;
        @(posedge i_clk);
        while (!data_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (last)
            msgs_sent++;
    endtask

    // Random payload; close=0 leaves the message open across the next phase
    task automatic send_message(input int len, input bit close);
        int k;
        for (k = 0; k < len; k++)
            send_word(8'($urandom_range(0, 255)), close && (k == len - 1));
    endtask

    // Drop valid and hold until every predicted word has come out
    task automatic wait_quiet();
        data_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // One register write per edge; the caller drops the enable
    task automatic write_reg(input logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cc20_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    // Write all seven registers; the 32-bit ones get junk in the upper half to
    // make sure it is dropped
    task automatic load_settings(input logic [63:0] ka, kb, kc, kd, nl,
                                 input logic [31:0] nh, ctr, input bit poke_spare);
        write_reg(cc20_pkg::CFG_KEY_A, ka);
        write_reg(cc20_pkg::CFG_KEY_B, kb);
        write_reg(cc20_pkg::CFG_KEY_C, kc);
        write_reg(cc20_pkg::CFG_KEY_D, kd);
        write_reg(cc20_pkg::CFG_NONCE_LO, nl);
        write_reg(cc20_pkg::CFG_NONCE_HI, {32'($urandom), nh});
        write_reg(cc20_pkg::CFG_INIT_CTR, {32'($urandom), ctr});
        if (poke_spare)
            write_reg(CFG_IDX_SPARE, {32'($urandom), 32'($urandom)});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly short messages, some crossing a block boundary; the phase
    // sends exactly its budget
    task automatic run_phase(input int budget, input bit with_hold);
        int sent_here;
        int len;
        int pick;
        bit close;
        sent_here = 0;
        // Stall the sink for a long stretch while words keep coming, so the
        // block fills and pushes back on its input
        if (with_hold)
            rx_hold_req = 1'b1;
        while (sent_here < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                len = $urandom_range(1, 8);
            else if (pick < 8)
                len = $urandom_range(9, 70);
            else
                len = $urandom_range(65, 160);
            if (len > budget - sent_here)
                len = budget - sent_here;
            // Only the final message of a phase may stay open
            close = (sent_here + len < budget) || ($urandom_range(0, 1) == 1);
            send_message(len, close);
            sent_here += len;
        end
    endtask

    // Sink side: random ready bursts, plus the long hold on request
    initial begin : sink_side
        int hold_left;
        hold_left       = 0;
        cipher_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                cipher_ch.ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                cipher_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 4);
                cipher_ch.ready <= 1'b0;
            end else begin
                cipher_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (data_ch.valid && data_ch.ready) ||
                (cipher_ch.valid && cipher_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: %0d cycles with no word moving, %0d results still due",
                 $time, WATCHDOG_LIMIT, pending);
        $display("[chacha20_stream_cipher] ERROR");
        $finish;
    end

    initial begin : stimulus
        int p;
        int k;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        data_ch.valid     = 1'b0;
        data_ch.data_byte = '0;
        data_ch.is_last   = 1'b0;
        tx_idle_en        = 1'b1;
        rx_idle_en        = 1'b1;
        rx_hold_req       = 1'b0;
        bytes_sent        = 0;
        msgs_sent         = 0;
        settings_used     = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings (zero key and nonce, counter 1): single-byte
        // messages at both byte extremes, then a short message of corner values
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        for (k = 0; k < 8; k++)
            send_word(CORNER_BYTES[k], k == 7);
        wait_quiet();

        // Directed, the well-known sample key and nonce with counter 1
        load_settings(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                      64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
                      64'h4A00_0000_0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
        for (k = 0; k < 8; k++)
            send_word(CORNER_BYTES[k], k == 7);
        send_word(8'hFF, 1'b1);
        wait_quiet();

        // All ones with the counter at its top: the second block wraps to zero.
        // Then leave a message open mid-block and rekey under it.
        load_settings('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, 1'b0);
        send_message(130, 1'b1);
        send_message(70, 1'b0);
        wait_quiet();

        // Zero key, all-ones nonce, counter 0; the open message continues on the
        // old counter and picks up the new key at its next block
        load_settings('0, '0, '0, '0, '1, '1, 32'h0000_0000, 1'b0);
        run_phase(80, 1'b0);
        wait_quiet();

        // Random settings; idling varies so some phases run with one side clean
        for (p = 0; p < 6; p++) begin
            tx_idle_en = (p % 3 != 1);
            rx_idle_en = (p % 3 != 2);
            load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                          (p == 4) ? 32'hFFFF_FFFE : $urandom, p == 0);
            run_phase(66, p == 2);
            wait_quiet();
        end

        // Closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, 1'b0);
        run_phase(60, 1'b0);

        // Drain, then give any stray word time to show up
        wait_quiet();
        repeat (BLOCK_LATENCY + 8) @(posedge i_clk);

        $display("ran %0d bytes in %0d messages under %0d register settings, %0d compared",
                 bytes_sent, msgs_sent, settings_used, bytes_checked);
        $display("incl. counter wrap, rekey inside a message, a spare index write, %0d-cycle stall",
                 LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("[chacha20_stream_cipher] OK");
        else
            $display("[chacha20_stream_cipher] ERROR");
        $finish;
    end

endmodule
